FILE: sv/per_user_flood_rate_limiter_defines.svh
// Assertion macros used by the flood rate limiter top level.
`ifndef PER_USER_FLOOD_RATE_LIMITER_DEFINES_SVH
`define PER_USER_FLOOD_RATE_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PUFRL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PUFRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PUFRL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PUFRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/pufrl_pkg.sv
// Shared types and constants of the per-user flood rate limiter.
package pufrl_pkg;

  localparam logic [1:0] OP_MESSAGE = 2'd0;
  localparam logic [1:0] OP_PART    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_PENALTY     = 2'd1;
  localparam logic [1:0] REG_MAX_SCORE   = 2'd2;
  localparam logic [1:0] REG_ACTION_KIND = 2'd3;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;

  localparam logic [23:0] PENALTY_RESET   = 24'd1000;
  localparam logic [23:0] MAX_SCORE_RESET = 24'd2000;

  // floor(x / 5) = (x * RECIP_FIVE) >> RECIP_SHIFT, exact for x below 2^28.
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [27:0] RECIP_FIVE  = 28'd214748365;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic scale;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: sv/pufrl_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module pufrl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pufrl_pkg::status_t status,
  output pufrl_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE,
    ST_COMMIT
  } state_t;

  state_t state;

  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && (state == ST_IDLE);
  assign cmd.lookup  = (state == ST_LOOKUP);
  assign cmd.scale   = (state == ST_SCALE);
  assign cmd.commit  = (state == ST_COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/pufrl_dp.sv
// Datapath with configuration registers, slot storage, credit arithmetic and result register.
module pufrl_dp #(
  parameter int unsigned USER_SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [1:0]         operation,
  input  logic [7:0]         user_slot,
  input  logic [31:0]        time_ms,
  input  pufrl_pkg::cmd_t    cmd,
  output pufrl_pkg::status_t status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               flood_detected,
  output logic [1:0]         action,
  output logic [23:0]        score_after
);

  localparam int unsigned DEPTH  = (USER_SLOTS < 256) ? USER_SLOTS : 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic        enable;
  logic [23:0] penalty_ms;
  logic [23:0] max_score_ms;
  logic [1:0]  action_kind;

  logic [1:0]        op_q;
  logic [ADDR_W-1:0] addr_q;
  logic              in_range_q;
  logic [31:0]       now_q;

  logic [55:0]       mem [DEPTH];
  logic [55:0]       rdata;
  logic [DEPTH-1:0]  slot_valid;

  logic [27:0] pen9_q;
  logic [55:0] prod;
  logic [24:0] init_q;

  logic               hit;
  logic [23:0]        init_sat;
  logic [23:0]        old_score;
  logic [31:0]        old_last;
  logic [31:0]        elapsed;
  logic [23:0]        elapsed_sat;
  logic signed [25:0] sum;
  logic               flood;
  logic [23:0]        capped;
  logic [23:0]        new_score;
  logic [1:0]         act;
  logic               is_msg;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      penalty_ms   <= pufrl_pkg::PENALTY_RESET;
      max_score_ms <= pufrl_pkg::MAX_SCORE_RESET;
      action_kind  <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        pufrl_pkg::REG_ENABLE:      enable       <= cfg_data[0];
        pufrl_pkg::REG_PENALTY:     penalty_ms   <= cfg_data;
        pufrl_pkg::REG_MAX_SCORE:   max_score_ms <= cfg_data;
        pufrl_pkg::REG_ACTION_KIND: action_kind  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= operation;
      addr_q     <= ADDR_W'(user_slot);
      in_range_q <= ({24'd0, user_slot} < 32'(USER_SLOTS));
      now_q      <= time_ms;
    end
    if (cmd.lookup) begin
      pen9_q <= ({4'd0, penalty_ms} << 3) + {4'd0, penalty_ms};
    end
    if (cmd.scale) begin
      init_q <= 25'(prod >> pufrl_pkg::RECIP_SHIFT);
    end
  end

  assign prod = pen9_q * pufrl_pkg::RECIP_FIVE;

  always_comb begin
    hit         = slot_valid[addr_q];
    init_sat    = (init_q > {1'b0, max_score_ms}) ? max_score_ms : init_q[23:0];
    old_score   = hit ? rdata[55:32] : init_sat;
    old_last    = hit ? rdata[31:0] : now_q;
    elapsed     = now_q - old_last;
    elapsed_sat = (elapsed > {8'd0, max_score_ms}) ? max_score_ms : elapsed[23:0];
    sum         = $signed({2'b00, old_score}) + $signed({2'b00, elapsed_sat})
                  - $signed({2'b00, penalty_ms});
    flood       = (sum <= 26'sd0);
    capped      = (sum > $signed({2'b00, max_score_ms})) ? max_score_ms : sum[23:0];
    new_score   = flood ? 24'd0 : capped;
    act         = (action_kind == pufrl_pkg::KIND_UNUSED) ? pufrl_pkg::ACT_NONE
                                                          : action_kind + 2'd1;
    is_msg      = (op_q == pufrl_pkg::OP_MESSAGE) && enable && in_range_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rdata <= mem[addr_q];
    end
    if (cmd.commit && is_msg) begin
      mem[addr_q] <= {new_score, now_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit) begin
      if (op_q == pufrl_pkg::OP_CLEAR) begin
        slot_valid <= '0;
      end else if (op_q == pufrl_pkg::OP_PART && in_range_q) begin
        slot_valid[addr_q] <= 1'b0;
      end else if (is_msg) begin
        slot_valid[addr_q] <= 1'b1;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      flood_detected <= is_msg && flood;
      action         <= (is_msg && flood) ? act : pufrl_pkg::ACT_NONE;
      score_after    <= is_msg ? new_score : 24'd0;
    end
  end

endmodule

FILE: sv/per_user_flood_rate_limiter.sv
// Top level of the per-user flood rate limiter.
// The edge that accepts a transaction captures its fields; the controller then
// steps through the slot memory read, the registered multiply that forms the
// initial credit of 1.8 times the penalty, and the credit update with write-back
// into the output register, held off while that register holds an untaken result.
// The controller accepts no new transaction until the last one is committed.
// A finished result may wait in the output register while the next transaction
// is accepted and worked on.
// There is no clearing pass after reset: slot valid bits reset at once.
`include "per_user_flood_rate_limiter_defines.svh"

module per_user_flood_rate_limiter #(
  parameter int unsigned USER_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  user_slot,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        flood_detected,
  output logic [1:0]  action,
  output logic [23:0] score_after
);

  pufrl_pkg::cmd_t    cmd;
  pufrl_pkg::status_t status;

  pufrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pufrl_dp #(
    .USER_SLOTS (USER_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .user_slot      (user_slot),
    .time_ms        (time_ms),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .flood_detected (flood_detected),
    .action         (action),
    .score_after    (score_after)
  );

  `PUFRL_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "accepted while busy")
  `PUFRL_ASSERT_NOW(a_flood_zero, clk, rst, out_valid && flood_detected, score_after == 24'd0, "flood with credit")
  `PUFRL_ASSERT_NOW(a_action_flood, clk, rst, out_valid && (action != pufrl_pkg::ACT_NONE), flood_detected, "action without flood")

endmodule

FILE: sim/tb_per_user_flood_rate_limiter.sv
// Self-checking testbench for the per-user flood rate limiter: directed and random traffic.
`timescale 1ns / 1ps

module tb_per_user_flood_rate_limiter;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_KICK  = 2'd0;
  localparam logic [1:0] KIND_BAN   = 2'd1;
  localparam logic [1:0] KIND_QUIET = 2'd2;
  localparam int SLOT_COUNT = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic        flood;
    logic [1:0]  act;
    logic [23:0] score;
  } credit_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [7:0]  user_slot;
  logic [31:0] time_ms;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        flood_detected;
  logic [1:0]  action;
  logic [23:0] score_after;

  logic        m_enable;
  logic [23:0] m_penalty;
  logic [23:0] m_ceiling;
  logic [1:0]  m_kind;
  logic        slot_live [SLOT_COUNT];
  logic [23:0] slot_credit [SLOT_COUNT];
  logic [31:0] slot_stamp [SLOT_COUNT];

  credit_result_t pending_results[$];

  int mismatches = 0;
  int transactions_in = 0;
  int results_checked = 0;
  int floods_seen = 0;

  int rx_mode = 0;
  int rx_hold = 0;
  int rx_left = 0;
  bit rx_on = 1'b1;
  int hold_requests = 0;
  int hold_taken = 0;

  bit tx_gaps = 1'b0;
  int tx_burst_left = 0;

  per_user_flood_rate_limiter #(
    .USER_SLOTS(SLOT_COUNT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .user_slot(user_slot),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .flood_detected(flood_detected),
    .action(action),
    .score_after(score_after)
  );

  always #2 clk = ~clk;

  function automatic credit_result_t apply_flood_rule(logic [1:0] op, logic [7:0] slot,
                                                      logic [31:0] now);
    credit_result_t r;
    longint ceiling;
    longint pen;
    longint start;
    longint credit;
    logic [31:0] elapsed;
    r = '0;
    if (op == pufrl_pkg::OP_CLEAR) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 1'b0;
    end else if (op == pufrl_pkg::OP_PART) begin
      slot_live[slot] = 1'b0;
    end else if (op == pufrl_pkg::OP_MESSAGE && m_enable) begin
      ceiling = longint'({40'd0, m_ceiling});
      pen = longint'({40'd0, m_penalty});
      if (!slot_live[slot]) begin
        start = (pen * 9) / 5;
        if (start > ceiling) start = ceiling;
        slot_live[slot] = 1'b1;
        slot_credit[slot] = start[23:0];
        slot_stamp[slot] = now;
      end
      elapsed = now - slot_stamp[slot];
      if (longint'({32'd0, elapsed}) > ceiling) elapsed = ceiling[31:0];
      credit = longint'({40'd0, slot_credit[slot]}) + longint'({32'd0, elapsed}) - pen;
      if (credit > ceiling) credit = ceiling;
      slot_stamp[slot] = now;
      if (credit <= 0) begin
        credit = 0;
        r.flood = 1'b1;
        r.act = (m_kind == pufrl_pkg::KIND_UNUSED) ? pufrl_pkg::ACT_NONE : m_kind + 2'd1;
      end
      slot_credit[slot] = credit[23:0];
      r.score = slot_credit[slot];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    credit_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, score", score_after, 0);
        end else begin
          want = pending_results.pop_front();
          if (flood_detected !== want.flood)
            report_mismatch("flood_detected", flood_detected, want.flood);
          if (action !== want.act) report_mismatch("action", action, want.act);
          if (score_after !== want.score) report_mismatch("score_after", score_after, want.score);
          results_checked++;
          if (want.flood) floods_seen++;
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_flood_rule(operation, user_slot, time_ms));
        transactions_in++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      rx_hold = HOLD_OFF_CYCLES;
    end
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      case (rx_mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: begin
          if (rx_left == 0) begin
            rx_on = ~rx_on;
            rx_left = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 6);
          end
          rx_left--;
          out_ready = rx_on;
        end
      endcase
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] slot, input logic [31:0] stamp);
    int gap;
    if (tx_burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      tx_burst_left = $urandom_range(1, 16);
    end
    tx_burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    user_slot = slot;
    time_ms = stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      pufrl_pkg::REG_ENABLE:      m_enable = data[0];
      pufrl_pkg::REG_PENALTY:     m_penalty = data;
      pufrl_pkg::REG_MAX_SCORE:   m_ceiling = data;
      pufrl_pkg::REG_ACTION_KIND: m_kind = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic en, input logic [23:0] pen, input logic [23:0] ceiling,
                            input logic [1:0] kind);
    write_reg(pufrl_pkg::REG_ENABLE, {23'd0, en});
    write_reg(pufrl_pkg::REG_PENALTY, pen);
    write_reg(pufrl_pkg::REG_MAX_SCORE, ceiling);
    write_reg(pufrl_pkg::REG_ACTION_KIND, {22'd0, kind});
  endtask

  task automatic test_reset_defaults();
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd100);
    send_item(pufrl_pkg::OP_PART, 8'd0, 32'd100);
    send_item(pufrl_pkg::OP_CLEAR, 8'd0, 32'd100);
    write_reg(pufrl_pkg::REG_ENABLE, 24'd1);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_directed_messages();
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd0);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd255, 32'hFFFF_FF00);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd255, 32'h0000_0100);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd255, 32'hFFFF_FFFF);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd255, 32'h7FFF_FFFF);
    send_item(pufrl_pkg::OP_PART, 8'd255, 32'h7FFF_FFFF);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd255, 32'h8000_0000);
    send_item(OP_UNUSED, 8'd0, 32'd5000);
    send_item(pufrl_pkg::OP_CLEAR, 8'd255, 32'd5000);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd5000);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd5000);
    wait_idle();
  endtask

  task automatic test_action_kinds();
    write_reg(pufrl_pkg::REG_ACTION_KIND, {22'd0, KIND_BAN});
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd5000);
    write_reg(pufrl_pkg::REG_ACTION_KIND, {22'd0, KIND_QUIET});
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd5000);
    write_reg(pufrl_pkg::REG_ACTION_KIND, {22'd0, pufrl_pkg::KIND_UNUSED});
    send_item(pufrl_pkg::OP_MESSAGE, 8'd0, 32'd5000);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_config(1'b1, 24'd0, 24'd0, KIND_KICK);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd7, 32'd5);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd7, 32'd1000);
    set_config(1'b1, 24'hFFFFFF, 24'hFFFFFF, KIND_QUIET);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd8, 32'd0);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd8, 32'hFFFF_FFFF);
    set_config(1'b1, 24'd0, 24'hFFFFFF, KIND_BAN);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd9, 32'd10);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd9, 32'd110);
    write_reg(pufrl_pkg::REG_MAX_SCORE, 24'd50);
    send_item(pufrl_pkg::OP_MESSAGE, 8'd9, 32'd110);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int count;
    int sel;
    int r2;
    logic [1:0] op;
    logic [7:0] slot;
    logic [31:0] stamp;
    logic [31:0] tnow;
    int unsigned pen;
    int unsigned span;
    tnow = $urandom;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(1'b1, pufrl_pkg::PENALTY_RESET, pufrl_pkg::MAX_SCORE_RESET, KIND_KICK);
        1: begin
          pen = $urandom_range(1000, 20000);
          set_config(1'b1, 24'(pen), 24'(pen + $urandom_range(1, 40000)),
                     2'($urandom_range(0, 3)));
        end
        2: set_config(1'b1, 24'd16777214, 24'hFFFFFF, KIND_QUIET);
        3: set_config(1'b1, 24'($urandom_range(1000, 100000)),
                      24'($urandom_range(1001, 24'hFFFFFF)), 2'($urandom_range(0, 3)));
        4: write_reg(pufrl_pkg::REG_ENABLE, 24'd0);
        default: set_config(1'b1, 24'($urandom_range(1000, 5000)), 24'hFFFFFF,
                            pufrl_pkg::KIND_UNUSED);
      endcase
      @(posedge clk);
      rx_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
      tx_gaps = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      count = (phase == 4) ? 40 : 290;
      for (int n = 0; n < count; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) op = pufrl_pkg::OP_PART;
        else if (sel < 10) op = pufrl_pkg::OP_CLEAR;
        else if (sel < 12) op = OP_UNUSED;
        else op = pufrl_pkg::OP_MESSAGE;
        slot = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        span = {8'd0, m_penalty};
        r2 = $urandom_range(0, 99);
        if (r2 < 5) begin
          stamp = $urandom;
        end else begin
          if (r2 < 8) tnow = tnow + $urandom;
          else if (r2 < 20) tnow = tnow + $urandom_range(0, 2 * span + 64);
          else tnow = tnow + $urandom_range(0, span / 4 + 16);
          stamp = tnow;
        end
        send_item(op, slot, stamp);
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    logic [31:0] tnow;
    set_config(1'b1, pufrl_pkg::PENALTY_RESET, pufrl_pkg::MAX_SCORE_RESET, KIND_BAN);
    @(posedge clk);
    rx_mode = 0;
    tx_gaps = 1'b0;
    hold_requests++;
    tnow = $urandom;
    for (int n = 0; n < 40; n++) begin
      tnow = tnow + $urandom_range(0, 400);
      send_item(pufrl_pkg::OP_MESSAGE, 8'($urandom_range(0, 3)), tnow);
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pufrl_pkg::REG_ENABLE;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = pufrl_pkg::OP_MESSAGE;
    user_slot = '0;
    time_ms = '0;
    m_enable = 1'b0;
    m_penalty = pufrl_pkg::PENALTY_RESET;
    m_ceiling = pufrl_pkg::MAX_SCORE_RESET;
    m_kind = KIND_KICK;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_live[i] = 1'b0;
      slot_credit[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_messages();
    test_action_kinds();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", pending_results.size(), 0);

    $display("Summary: %0d transactions in, %0d results checked, %0d floods, %0d mismatches",
             transactions_in, results_checked, floods_seen, mismatches);
    $display("Covered reset defaults, time wrap and saturation, all action kinds, register");
    $display("extremes, random traffic under idling and a long output hold-off.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
